// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks on the rising clock edge, off while reset is low.
`ifndef ASSERT_OFF
// pre holds at an edge, so post holds at the same edge
`define ASSERT_IMPLY(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
		else $error("same-cycle check failed");
// pre holds at an edge, so post holds at the next edge
`define ASSERT_NEXT(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ck, rn, pre, post)
`define ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif

`endif

// ===== rtl/core/sqv_pkg.sv =====
`default_nettype none

package sqv_pkg;

	// Beat spacing: four vertices per request, one vertex a cycle
	localparam int ITEM_CYCLES = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIVOT_X,
		REG_PIVOT_Y,
		REG_QUAD_W,
		REG_QUAD_H,
		REG_ATLAS_U,
		REG_ATLAS_V,
		REG_FRAME_U,
		REG_FRAME_V
	} reg_idx_t;

	// Vertex order within a quad
	typedef enum logic [1:0] {
		CORNER_TL,
		CORNER_TR,
		CORNER_BR,
		CORNER_BL
	} corner_t;

	// Quadrant of the rotation angle
	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	// Field and datapath widths
	localparam int POS_W      = 32;
	localparam int SCALE_W    = 16;
	localparam int SCALE_FRAC = 8;
	localparam int SCALE_HALF = 128;
	localparam int OFS_W      = 33;                  // -pivot + size
	localparam int SCP_W      = OFS_W + SCALE_W;     // offset times scale
	localparam int SC_W       = SCP_W - SCALE_FRAC;  // scaled offset, Q16.16
	localparam int Q30_W      = 31;                  // Q30 values up to 1.0
	localparam int TRIG_SHIFT = 14;
	localparam int Q16_HALF   = 8192;
	localparam int TRIG_W     = 19;                  // signed Q16 sine/cosine
	localparam int PROD_W     = SC_W + TRIG_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int ROT_FRAC   = 16;
	localparam int ROT_HALF   = 32768;
	localparam int ROT_W      = SUM_W - ROT_FRAC;
	localparam int TEX_W      = 18;
	localparam int TEXB_W     = 26;                  // origin + index * size
	localparam int TEXS_W     = TEXB_W + 1;          // plus one frame size
	localparam int SIZE_W     = 31;
	localparam int IDX_W      = 8;

	localparam logic [TEX_W-1:0] TEX_MAX = 18'h3FFFF;

	// Quarter-wave polynomial t*(A - t^2*(B - t^2*C)), all Q30
	localparam logic [Q30_W-1:0] TRIG_A  = 31'd1686629713;
	localparam logic [Q30_W-1:0] TRIG_B  = 31'd688904866;
	localparam logic [Q30_W-1:0] TRIG_C  = 31'd76016977;
	localparam logic [Q30_W-1:0] ONE_Q30 = 31'd1073741824;

	// One Horner cell per remaining coefficient, innermost first
	localparam int POLY_CELLS = 2;
	localparam logic [Q30_W-1:0] HORNER_K [POLY_CELLS] = '{TRIG_B, TRIG_A};

	// Sine lane and cosine lane
	localparam int NUM_LANES = 2;

	// Square, cells, final product, quadrant fold
	localparam int TRIG_LAT = POLY_CELLS + 3;

	typedef struct packed {
		logic [Q30_W-1:0] t;
		logic [Q30_W-1:0] t2;
		logic [Q30_W-1:0] acc;
	} poly_lane_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
	} trig_t;

	typedef struct packed {
		logic signed [SC_W-1:0]  sx_near;
		logic signed [SC_W-1:0]  sx_far;
		logic signed [SC_W-1:0]  sy_near;
		logic signed [SC_W-1:0]  sy_far;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [TEXB_W-1:0]       u0;
		logic [TEXB_W-1:0]       v0;
	} front_item_t;

	typedef struct packed {
		front_item_t geo;
		trig_t       trig;
	} vtx_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqv_poly_cell.sv =====
`default_nettype none

module sqv_poly_cell
	import sqv_pkg::*;
(
	input  logic             clk,
	input  logic [Q30_W-1:0] coef,
	input  poly_lane_t       lane_in,
	output poly_lane_t       lane_out
);

	logic [2*Q30_W-1:0] prod;
	logic [Q30_W:0]     acc_next;
	poly_lane_t         lane_s1;

	// One Horner step: coef - t^2 * acc, truncated to Q30
	assign prod     = (2*Q30_W)'(lane_in.t2) * (2*Q30_W)'(lane_in.acc);
	assign acc_next = (Q30_W+1)'(coef) - prod[2*Q30_W-1:Q30_W-1];

	// Hand t and t^2 on to the neighbour with the new accumulator
	always_ff @(posedge clk) begin
		lane_s1 <= '{t: lane_in.t, t2: lane_in.t2, acc: acc_next[Q30_W-1:0]};
	end

	assign lane_out = lane_s1;

endmodule

`default_nettype wire

// ===== rtl/core/sqv_sincos.sv =====
`default_nettype none

module sqv_sincos
	import sqv_pkg::*;
(
	input  logic             clk,
	input  logic [Q30_W-1:0] t,
	input  logic [Q30_W-1:0] tn,
	input  quad_t            quad,
	output trig_t            trig
);

	poly_lane_t      sq_s   [NUM_LANES];
	poly_lane_t      cell_s [NUM_LANES][POLY_CELLS];
	logic [Q30_W:0]  fin_s  [NUM_LANES];
	quad_t           quad_s [POLY_CELLS+2];
	logic [Q30_W+1:0] rnd_t;
	logic [Q30_W+1:0] rnd_n;
	logic signed [TRIG_W-1:0] pt;
	logic signed [TRIG_W-1:0] pn;
	trig_t           trig_next;
	trig_t           trig_s;

	genvar l, c;
	generate
		for (l = 0; l < NUM_LANES; l++) begin : g_lane
			logic [Q30_W-1:0]   arg;
			logic [2*Q30_W-1:0] sq_prod;
			logic [2*Q30_W-1:0] fin_prod;

			// Lane 0 runs on t, lane 1 on one minus t
			assign arg     = (l == 0) ? t : tn;
			assign sq_prod = (2*Q30_W)'(arg) * (2*Q30_W)'(arg);

			// Square the argument and seed the accumulator with the inner coefficient
			always_ff @(posedge clk) begin
				sq_s[l] <= '{t: arg, t2: sq_prod[2*Q30_W-2:Q30_W-1], acc: TRIG_C};
			end

			// Row of Horner cells
			for (c = 0; c < POLY_CELLS; c++) begin : g_cell
				if (c == 0) begin : g_head
					sqv_poly_cell u_cell (
						.clk      (clk),
						.coef     (HORNER_K[c]),
						.lane_in  (sq_s[l]),
						.lane_out (cell_s[l][c])
					);
				end else begin : g_body
					sqv_poly_cell u_cell (
						.clk      (clk),
						.coef     (HORNER_K[c]),
						.lane_in  (cell_s[l][c-1]),
						.lane_out (cell_s[l][c])
					);
				end
			end

			// Final multiply by t
			assign fin_prod = (2*Q30_W)'(cell_s[l][POLY_CELLS-1].t)
				* (2*Q30_W)'(cell_s[l][POLY_CELLS-1].acc);

			always_ff @(posedge clk) begin
				fin_s[l] <= fin_prod[2*Q30_W-1:Q30_W-1];
			end
		end
	endgenerate

	// Carry the quadrant alongside the polynomial
	always_ff @(posedge clk) begin
		quad_s[0] <= quad;
		for (int i = 1; i < POLY_CELLS + 2; i++) begin
			quad_s[i] <= quad_s[i-1];
		end
	end

	// Round Q30 to Q16 and fold by quadrant
	always_comb begin
		rnd_t = (Q30_W+2)'(fin_s[0]) + (Q30_W+2)'(Q16_HALF);
		rnd_n = (Q30_W+2)'(fin_s[1]) + (Q30_W+2)'(Q16_HALF);
		pt    = {1'b0, rnd_t[Q30_W:TRIG_SHIFT]};
		pn    = {1'b0, rnd_n[Q30_W:TRIG_SHIFT]};
		case (quad_s[POLY_CELLS+1])
			QUAD_I: begin
				trig_next = '{sn: pt, cs: pn};
			end
			QUAD_II: begin
				trig_next = '{sn: pn, cs: -pt};
			end
			QUAD_III: begin
				trig_next = '{sn: -pt, cs: -pn};
			end
			QUAD_IV: begin
				trig_next = '{sn: -pn, cs: pt};
			end
			default: begin
				trig_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		trig_s <= trig_next;
	end

	assign trig = trig_s;

endmodule

`default_nettype wire

// ===== rtl/core/sqv_corner.sv =====
`default_nettype none

`include "assert_macros.svh"

module sqv_corner
	import sqv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  vtx_item_t               item,
	input  logic [TEX_W-1:0]        frame_u,
	input  logic [TEX_W-1:0]        frame_v,
	output logic                    vert_strobe,
	output logic signed [POS_W-1:0] vert_x,
	output logic signed [POS_W-1:0] vert_y,
	output logic [TEX_W-1:0]        tex_u,
	output logic [TEX_W-1:0]        tex_v,
	output corner_t                 corner,
	output logic                    last
);

	localparam logic signed [ROT_W-1:0] ROT_MAX = ROT_W'(64'sh7FFFFFFF);
	localparam logic signed [ROT_W-1:0] ROT_MIN = ROT_W'(-64'sh80000000);

	function automatic logic [POS_W-1:0] sat_vert(input logic signed [ROT_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v > ROT_MAX) begin
			r = 32'h7FFFFFFF;
		end else if (v < ROT_MIN) begin
			r = 32'h80000000;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [TEX_W-1:0] sat_tex(input logic [TEXS_W-1:0] v);
		logic [TEX_W-1:0] r;
		if (v > TEXS_W'(TEX_MAX)) begin
			r = TEX_MAX;
		end else begin
			r = v[TEX_W-1:0];
		end
		return r;
	endfunction

	vtx_item_t               hold_q;
	corner_t                 cnt_q;
	logic                    run_q;

	logic                    far_x;
	logic                    far_y;
	logic signed [SC_W-1:0]  sx;
	logic signed [SC_W-1:0]  sy;
	logic [TEXS_W-1:0]       u_sum;
	logic [TEXS_W-1:0]       v_sum;

	logic                    vld_s1;
	corner_t                 corner_s1;
	logic signed [PROD_W-1:0] pxc_s1;
	logic signed [PROD_W-1:0] pys_s1;
	logic signed [PROD_W-1:0] pxs_s1;
	logic signed [PROD_W-1:0] pyc_s1;
	logic signed [POS_W-1:0] posx_s1;
	logic signed [POS_W-1:0] posy_s1;
	logic [TEX_W-1:0]        texu_s1;
	logic [TEX_W-1:0]        texv_s1;

	logic signed [SUM_W-1:0] x_sum;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [ROT_W-1:0] x_rot;
	logic signed [ROT_W-1:0] y_rot;
	logic signed [ROT_W-1:0] x_pos;
	logic signed [ROT_W-1:0] y_pos;

	logic                    vld_s2;
	logic signed [POS_W-1:0] vx_s2;
	logic signed [POS_W-1:0] vy_s2;
	logic [TEX_W-1:0]        tu_s2;
	logic [TEX_W-1:0]        tv_s2;
	corner_t                 corner_s2;
	logic                    last_s2;

	// Step through the four corners of the held request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= CORNER_TL;
		end else if (item_valid) begin
			run_q <= 1'b1;
			cnt_q <= CORNER_TL;
		end else if (run_q) begin
			if (cnt_q == CORNER_BL) begin
				run_q <= 1'b0;
			end
			cnt_q <= corner_t'(cnt_q + 2'd1);
		end
	end

	// Hold the request while its corners go out
	always_ff @(posedge clk) begin
		if (item_valid) begin
			hold_q <= item;
		end
	end

	// Pick near or far offsets and texture edges for this corner
	always_comb begin
		far_x = (cnt_q == CORNER_TR) || (cnt_q == CORNER_BR);
		far_y = (cnt_q == CORNER_BR) || (cnt_q == CORNER_BL);
		sx    = far_x ? hold_q.geo.sx_far : hold_q.geo.sx_near;
		sy    = far_y ? hold_q.geo.sy_far : hold_q.geo.sy_near;
		u_sum = TEXS_W'(hold_q.geo.u0) + (far_x ? TEXS_W'(frame_u) : '0);
		v_sum = TEXS_W'(hold_q.geo.v0) + (far_y ? TEXS_W'(frame_v) : '0);
	end

	// Rotation products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		corner_s1 <= cnt_q;
		pxc_s1    <= PROD_W'(sx) * PROD_W'(hold_q.trig.cs);
		pys_s1    <= PROD_W'(sy) * PROD_W'(hold_q.trig.sn);
		pxs_s1    <= PROD_W'(sx) * PROD_W'(hold_q.trig.sn);
		pyc_s1    <= PROD_W'(sy) * PROD_W'(hold_q.trig.cs);
		posx_s1   <= hold_q.geo.pos_x;
		posy_s1   <= hold_q.geo.pos_y;
		texu_s1   <= sat_tex(u_sum);
		texv_s1   <= sat_tex(v_sum);
	end

	// Combine, round to Q16.16 and translate
	always_comb begin
		x_sum = SUM_W'(pxc_s1) - SUM_W'(pys_s1) + SUM_W'(ROT_HALF);
		y_sum = SUM_W'(pxs_s1) + SUM_W'(pyc_s1) + SUM_W'(ROT_HALF);
		x_rot = x_sum[SUM_W-1:ROT_FRAC];
		y_rot = y_sum[SUM_W-1:ROT_FRAC];
		x_pos = x_rot + ROT_W'(posx_s1);
		y_pos = y_rot + ROT_W'(posy_s1);
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		vx_s2     <= sat_vert(x_pos);
		vy_s2     <= sat_vert(y_pos);
		tu_s2     <= texu_s1;
		tv_s2     <= texv_s1;
		corner_s2 <= corner_s1;
		last_s2   <= (corner_s1 == CORNER_BL);
	end

	assign vert_strobe = vld_s2;
	assign vert_x      = vx_s2;
	assign vert_y      = vy_s2;
	assign tex_u       = tu_s2;
	assign tex_v       = tv_s2;
	assign corner      = corner_s2;
	assign last        = last_s2;

	// A new request never cuts the current quad short
	`ASSERT_IMPLY(a_no_cut, clk, arst_n, item_valid, !run_q || cnt_q == CORNER_BL)
	// The four beats of a quad come back to back
	`ASSERT_NEXT(a_quad_runs, clk, arst_n, vert_strobe && !last, vert_strobe)
	// The last beat is the bottom-left corner and no other
	`ASSERT_IMPLY(a_last_bl, clk, arst_n, vert_strobe, last == (corner == CORNER_BL))

endmodule

`default_nettype wire

// ===== rtl/core/sprite_quad_vertex_gen_top.sv =====
// Flow: a taken request is captured, runs through the sine and cosine pipeline beside the
//   delayed geometry; the corner sequencer then sends its four vertices back to back.
// Throughput: the corner sequencer drives one vertex a cycle onto the single result port;
//   busy, high after each request, holds off start until its four vertices have a slot.
// The result port has no back-pressure: each vertex is shown for exactly one cycle.
// Reset clears busy, the pipeline valids and the sequencer, and loads register defaults.
`default_nettype none

`include "assert_macros.svh"

module sprite_quad_vertex_gen_top
	import sqv_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    start,
	output logic                    busy,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [IDX_W-1:0]        frame_col,
	input  logic [IDX_W-1:0]        frame_row,
	input  logic [15:0]             angle,
	input  logic signed [SCALE_W-1:0] scale_x,
	input  logic signed [SCALE_W-1:0] scale_y,

	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [POS_W-1:0]        cfg_data,

	output logic                    vert_strobe,
	output logic signed [POS_W-1:0] vert_x,
	output logic signed [POS_W-1:0] vert_y,
	output logic [TEX_W-1:0]        tex_u,
	output logic [TEX_W-1:0]        tex_v,
	output logic [1:0]              corner,
	output logic                    last
);

	function automatic logic signed [SC_W-1:0] scale_round(
		input logic signed [OFS_W-1:0]   ofs,
		input logic signed [SCALE_W-1:0] sc
	);
		logic signed [SCP_W-1:0] p;
		p = SCP_W'(ofs) * SCP_W'(sc) + SCP_W'(SCALE_HALF);
		return p[SCP_W-1:SCALE_FRAC];
	endfunction

	// Configuration registers
	logic signed [POS_W-1:0] pivot_x_q;
	logic signed [POS_W-1:0] pivot_y_q;
	logic [SIZE_W-1:0]       quad_w_q;
	logic [SIZE_W-1:0]       quad_h_q;
	logic [TEX_W-1:0]        atlas_u_q;
	logic [TEX_W-1:0]        atlas_v_q;
	logic [TEX_W-1:0]        frame_u_q;
	logic [TEX_W-1:0]        frame_v_q;

	logic [1:0]              busy_cnt_q;
	logic                    accept;

	logic [ANGLE_BITS-1:0]   ang_a;
	logic [Q30_W-1:0]        t_in;
	logic [Q30_W-1:0]        tn_in;

	logic [TRIG_LAT:0]       vld_s;
	logic signed [POS_W-1:0] pos_x_s1;
	logic signed [POS_W-1:0] pos_y_s1;
	logic [IDX_W-1:0]        col_s1;
	logic [IDX_W-1:0]        row_s1;
	logic signed [SCALE_W-1:0] scale_x_s1;
	logic signed [SCALE_W-1:0] scale_y_s1;
	logic [Q30_W-1:0]        t_s1;
	logic [Q30_W-1:0]        tn_s1;
	quad_t                   quad_s1;

	logic signed [OFS_W-1:0] ox_near;
	logic signed [OFS_W-1:0] ox_far;
	logic signed [OFS_W-1:0] oy_near;
	logic signed [OFS_W-1:0] oy_far;
	front_item_t             front_next;
	front_item_t             front_s [TRIG_LAT];

	trig_t                   trig;
	vtx_item_t               item;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_x_q <= '0;
			pivot_y_q <= '0;
			quad_w_q  <= 31'd65536;
			quad_h_q  <= 31'd65536;
			atlas_u_q <= '0;
			atlas_v_q <= '0;
			frame_u_q <= 18'd65536;
			frame_v_q <= 18'd65536;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_PIVOT_X: pivot_x_q <= cfg_data;
				REG_PIVOT_Y: pivot_y_q <= cfg_data;
				REG_QUAD_W:  quad_w_q  <= cfg_data[SIZE_W-1:0];
				REG_QUAD_H:  quad_h_q  <= cfg_data[SIZE_W-1:0];
				REG_ATLAS_U: atlas_u_q <= cfg_data[TEX_W-1:0];
				REG_ATLAS_V: atlas_v_q <= cfg_data[TEX_W-1:0];
				REG_FRAME_U: frame_u_q <= cfg_data[TEX_W-1:0];
				REG_FRAME_V: frame_v_q <= cfg_data[TEX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold off the next request until this one's four beats have a slot
	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= '0;
		end else if (accept) begin
			busy_cnt_q <= 2'(ITEM_CYCLES - 1);
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// Split the angle into quadrant and Q30 fraction
	always_comb begin
		ang_a = ANGLE_BITS'(angle);
		t_in  = {1'b0, ang_a[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
		tn_in = ONE_Q30 - t_in;
	end

	// Valid bits down the front pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[TRIG_LAT-1:0], accept};
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			col_s1     <= frame_col;
			row_s1     <= frame_row;
			scale_x_s1 <= scale_x;
			scale_y_s1 <= scale_y;
			t_s1       <= t_in;
			tn_s1      <= tn_in;
			quad_s1    <= quad_t'(ang_a[ANGLE_BITS-1 -: 2]);
		end
	end

	// Offsets from the pivot, scaled, and the frame's texture origin
	always_comb begin
		ox_near = -(OFS_W'(pivot_x_q));
		oy_near = -(OFS_W'(pivot_y_q));
		ox_far  = ox_near + $signed(OFS_W'(quad_w_q));
		oy_far  = oy_near + $signed(OFS_W'(quad_h_q));
		front_next.sx_near = scale_round(ox_near, scale_x_s1);
		front_next.sx_far  = scale_round(ox_far, scale_x_s1);
		front_next.sy_near = scale_round(oy_near, scale_y_s1);
		front_next.sy_far  = scale_round(oy_far, scale_y_s1);
		front_next.pos_x   = pos_x_s1;
		front_next.pos_y   = pos_y_s1;
		front_next.u0      = TEXB_W'(atlas_u_q) + TEXB_W'(col_s1) * TEXB_W'(frame_u_q);
		front_next.v0      = TEXB_W'(atlas_v_q) + TEXB_W'(row_s1) * TEXB_W'(frame_v_q);
	end

	// Delay the geometry to meet the sine and cosine
	always_ff @(posedge clk) begin
		front_s[0] <= front_next;
		for (int i = 1; i < TRIG_LAT; i++) begin
			front_s[i] <= front_s[i-1];
		end
	end

	sqv_sincos u_sincos (
		.clk  (clk),
		.t    (t_s1),
		.tn   (tn_s1),
		.quad (quad_s1),
		.trig (trig)
	);

	assign item = '{geo: front_s[TRIG_LAT-1], trig: trig};

	sqv_corner u_corner (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (vld_s[TRIG_LAT]),
		.item        (item),
		.frame_u     (frame_u_q),
		.frame_v     (frame_v_q),
		.vert_strobe (vert_strobe),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.corner      (corner),
		.last        (last)
	);

	// No request enters the pipeline while vld_s[1], vld_s[2] or vld_s[3] is still set
	`ASSERT_IMPLY(a_spacing, clk, arst_n, vld_s[0], !vld_s[1] && !vld_s[2] && !vld_s[3])
	// A taken request has busy high in the following cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy)

endmodule

`default_nettype wire
